// File: rtl/slp_pkg.sv
// Shared types and constants for the sync/length packet deframer.
package slp_pkg;

    localparam logic [7:0]  SYNC_BYTE        = 8'hFF;
    localparam logic [15:0] HEADER_LEN       = 16'd4;
    localparam logic [15:0] MAX_LEN_RESET    = 16'd2048;
    localparam int          BYTE_W           = 8;
    localparam int          LEN_W            = 16;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_DISCARD = 2'd2,
        KIND_BADLEN  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_CODE    = 5'b00010,
        PH_LEN_LO  = 5'b00100,
        PH_LEN_HI  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] packet_code;
        logic [LEN_W-1:0]  total_length;
        logic              last;
    } t_result;

endpackage

// File: rtl/slp_parser.sv
// Header parser state machine: turns one received byte into at most one result.
module slp_parser
    import slp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_advance,
    input  logic [LEN_W-1:0]  i_max_len,
    output logic              o_res_valid,
    output t_result           o_res
);

    t_phase            r_phase,     n_phase;
    logic [BYTE_W-1:0] r_code,      n_code;
    logic [BYTE_W-1:0] r_len_lo,    n_len_lo;
    logic [LEN_W-1:0]  r_len,       n_len;
    logic [LEN_W-1:0]  r_remain,    n_remain;
    logic [LEN_W-1:0]  rx_len;
    logic              take;

    assign take   = i_valid & i_advance;
    assign rx_len = {i_byte, r_len_lo};

    always_comb begin
        n_phase     = r_phase;
        n_code      = r_code;
        n_len_lo    = r_len_lo;
        n_len       = r_len;
        n_remain    = r_remain;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_CODE: begin
                n_code  = i_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len_lo = i_byte;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len              = rx_len;
                o_res.packet_code  = r_code;
                o_res.total_length = rx_len;
                o_res.last         = 1'b1;
                if (rx_len < HEADER_LEN || rx_len > i_max_len) begin
                    n_phase     = PH_HUNT;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_BADLEN;
                end else if (rx_len == HEADER_LEN) begin
                    n_phase     = PH_HUNT;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_EMPTY;
                end else begin
                    n_remain = rx_len - HEADER_LEN;
                    n_phase  = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_PAYLOAD;
                o_res.payload_byte = i_byte;
                o_res.packet_code  = r_code;
                o_res.total_length = r_len;
                o_res.last         = (r_remain <= 16'd1);
                if (r_remain <= 16'd1) begin
                    n_remain = '0;
                    n_phase  = PH_HUNT;
                end else begin
                    n_remain = r_remain - 16'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (i_byte == SYNC_BYTE) begin
                    n_phase = PH_CODE;
                end else begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_DISCARD;
                    o_res.payload_byte = i_byte;
                    o_res.last         = 1'b1;
                end
            end
        endcase
        o_res_valid = o_res_valid & i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_code   <= '0;
            r_len_lo <= '0;
            r_len    <= '0;
            r_remain <= '0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_len_lo <= n_len_lo;
            r_len    <= n_len;
            r_remain <= n_remain;
        end
    end

endmodule

// File: rtl/slp_out_stage.sv
// Result register on the master side of the deframer.
module slp_out_stage
    import slp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_advance = ~r_valid | i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/sync_length_packet_deframer.sv
// Top level of the sync/length packet deframer.
// Takes one received byte per cycle, unless held off by s_axis_tready, and cuts
// the stream into packets framed as 0xFF, code byte, 16-bit little-endian total
// length (header included), payload. Each byte passes an input register, the
// header state machine, and a result register; with the output side ready the
// block sustains one byte per cycle. Bytes outside a packet come out as
// discards, lengths below 4 or above max_packet_length as a bad-length event, a
// length of exactly 4 as one empty-packet event. Write the limit (reset 2048)
// only while no request is in flight.
module sync_length_packet_deframer
    import slp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [LEN_W-1:0]  i_cfg_wr_data,  // max_packet_length
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [7:0] payload_byte, [15:8] packet_code,
                                              // [31:16] total_length
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    output logic              m_axis_tlast
);

    logic [LEN_W-1:0]  r_max_len;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              advance;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    slp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_advance   (advance),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    slp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (m_axis_tready),
        .o_advance   (advance),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {out_res.total_length, out_res.packet_code, out_res.payload_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_event_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |-> m_axis_tlast)
        else $error("packet event without last");

    a_discard_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_DISCARD |-> m_axis_tdata[31:8] == 24'd0)
        else $error("discarded byte carries header fields");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_EMPTY |-> m_axis_tdata[31:16] == HEADER_LEN)
        else $error("empty packet with wrong length");

endmodule

// File: tb/sv/deframer_checker.sv
// Checker for the packet deframer: predicts results from accepted requests and compares them.
`timescale 1ns / 100ps

module deframer_checker
    import slp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_req_byte,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_data,
    input  logic [1:0]  i_rsp_kind,
    input  logic        i_rsp_last,
    output int          o_fail_count,
    output int          o_pending
);

    t_result     expected_q[$];
    int          fail_total = 0;

    // predictor state
    t_phase      rx_phase;
    logic [7:0]  hdr_code;
    logic [7:0]  len_lo;
    logic [15:0] hdr_len;
    logic [15:0] bytes_left;
    logic [15:0] max_len;

    assign o_fail_count = fail_total;

    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        r = '0;
        case (rx_phase)
            PH_CODE: begin
                hdr_code = b;
                rx_phase = PH_LEN_LO;
                return 1'b0;
            end
            PH_LEN_LO: begin
                len_lo   = b;
                rx_phase = PH_LEN_HI;
                return 1'b0;
            end
            PH_LEN_HI: begin
                hdr_len        = {b, len_lo};
                r.packet_code  = hdr_code;
                r.total_length = hdr_len;
                r.last         = 1'b1;
                if (hdr_len < HEADER_LEN || hdr_len > max_len) begin
                    rx_phase = PH_HUNT;
                    r.kind   = KIND_BADLEN;
                    return 1'b1;
                end
                if (hdr_len == HEADER_LEN) begin
                    rx_phase = PH_HUNT;
                    r.kind   = KIND_EMPTY;
                    return 1'b1;
                end
                bytes_left = hdr_len - HEADER_LEN;
                rx_phase   = PH_PAYLOAD;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                r.packet_code  = hdr_code;
                r.total_length = hdr_len;
                r.last         = (bytes_left <= 16'd1);
                if (r.last) begin
                    bytes_left = '0;
                    rx_phase   = PH_HUNT;
                end else begin
                    bytes_left = bytes_left - 16'd1;
                end
                return 1'b1;
            end
            default: begin
                rx_phase = PH_HUNT;
                if (b == SYNC_BYTE) begin
                    rx_phase = PH_CODE;
                    return 1'b0;
                end
                r.kind         = KIND_DISCARD;
                r.payload_byte = b;
                r.last         = 1'b1;
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            rx_phase   = PH_HUNT;
            hdr_code   = '0;
            len_lo     = '0;
            hdr_len    = '0;
            bytes_left = '0;
            max_len    = MAX_LEN_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                max_len = i_cfg_wr_data;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got.kind         = t_kind'(i_rsp_kind);
                got.payload_byte = i_rsp_data[7:0];
                got.packet_code  = i_rsp_data[15:8];
                got.total_length = i_rsp_data[31:16];
                got.last         = i_rsp_last;
                if (expected_q.size() == 0) begin
                    $error("unexpected result: kind %0d byte %02h code %02h len %0d",
                           got.kind, got.payload_byte, got.packet_code, got.total_length);
                    fail_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        fail_total++;
                    end
                    if (got.payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %02h, got %02h",
                               want.payload_byte, got.payload_byte);
                        fail_total++;
                    end
                    if (got.packet_code !== want.packet_code) begin
                        $error("packet_code: expected %02h, got %02h",
                               want.packet_code, got.packet_code);
                        fail_total++;
                    end
                    if (got.total_length !== want.total_length) begin
                        $error("total_length: expected %0d, got %0d",
                               want.total_length, got.total_length);
                        fail_total++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fail_total++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (deframe_byte(i_req_byte, fresh)) begin
                    expected_q.push_back(fresh);
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the packet deframer: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_top;
    import slp_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    logic        rx_hold_req;
    int          burst_left;
    bit          gaps_on;
    int          bytes_sent;
    int          cur_max_len;
    int          idle_cycles;

    sync_length_packet_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    deframer_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_byte    (s_axis_tdata),
        .i_rsp_valid   (m_axis_tvalid),
        .i_rsp_ready   (m_axis_tready),
        .i_rsp_data    (m_axis_tdata),
        .i_rsp_kind    (m_axis_tuser),
        .i_rsp_last    (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: stall rate changes per segment; one long hold on request
    initial begin : rx_side
        int   seg_left;
        int   stall_pct;
        int   hold_left;
        logic hold_seen;
        m_axis_tready = 1'b0;
        seg_left      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        hold_seen     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !hold_seen) begin
                hold_left = HOLD_CYCLES;
            end
            hold_seen = rx_hold_req;
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 200);
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 20) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_axis_tdata  <= b;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] code, input logic [15:0] len);
        send_byte(SYNC_BYTE);
        send_byte(code);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    // sender holds off until every expected result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [15:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        cur_max_len = int'(v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed frames with short payloads, some noise and broken frames
    task automatic run_random(input int n);
        int stop;
        int pick;
        int len;
        int cap;
        int n_pay;
        stop = bytes_sent + n;
        while (bytes_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end else if (pick < 22 || cur_max_len < 4) begin
                if (cur_max_len < 65535 && $urandom_range(1)) begin
                    len = $urandom_range(cur_max_len + 1, 65535);
                end else begin
                    len = $urandom_range(0, 3);
                end
                send_header(8'($urandom_range(255)), 16'(len));
            end else begin
                cap   = (cur_max_len < 40) ? cur_max_len : 40;
                len   = $urandom_range(4, cap);
                n_pay = len - 4;
                if ($urandom_range(19) == 0) begin
                    n_pay = $urandom_range(0, n_pay);
                end
                send_header(8'($urandom_range(255)), 16'(len));
                repeat (n_pay) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] v;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rx_hold_req   = 1'b0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        bytes_sent    = 0;
        cur_max_len   = int'(MAX_LEN_RESET);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit of 2048
        send_byte(8'h00);
        send_byte(8'hFE);
        send_header(8'hFF, 16'd0);
        send_header(8'h00, 16'd4);
        send_header(8'h5A, 16'hFFFF);
        send_header(8'h81, 16'd7);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_header(8'h3C, 16'd2049);
        wait_drained();

        // limit below the header size rejects everything
        write_max_len(16'd0);
        send_header(8'h11, 16'd4);
        send_header(8'h22, 16'd0);
        wait_drained();
        write_max_len(16'd3);
        send_header(8'h33, 16'd3);
        wait_drained();

        write_max_len(16'd4);
        send_header(8'h44, 16'd4);
        send_header(8'h45, 16'd5);
        wait_drained();

        // one long frame under the largest limit
        write_max_len(16'hFFFF);
        send_header(8'hC3, 16'd260);
        repeat (256) send_byte(8'($urandom_range(255)));
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            case (p % 4)
                0: v = 16'($urandom_range(4, 40));
                1: v = MAX_LEN_RESET;
                2: v = 16'($urandom_range(0, 65535));
                default: v = 16'($urandom_range(5, 12));
            endcase
            write_max_len(v);
            gaps_on = !(p == 1 || p == 2 || p == 5);
            if (p == 2) begin
                rx_hold_req <= 1'b1;
            end
            run_random(210);
            rx_hold_req <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
